/* design/xbr_pkg.sv */
// xbr_pkg: shared types, protocol byte codes and the crc-16 byte update
// for the xmodem block receiver. no dependencies.
package xbr_pkg;

    localparam logic [7:0] SOH = 8'h01;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] EOT = 8'h04;
    localparam logic [7:0] ACK = 8'h06;
    localparam logic [7:0] NAK = 8'h15;
    localparam logic [7:0] CAN = 8'h18;
    localparam logic [7:0] CCH = 8'h43;

    localparam logic [10:0] SHORT_LEN = 11'd128;
    localparam logic [10:0] LONG_LEN  = 11'd1024;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [4:0] INIT_RETRIES_RST = 5'd30;
    localparam logic [4:0] PKT_RETRIES_RST  = 5'd10;

    // register indexes on the config port (paddr[3:2])
    localparam logic [1:0] REG_CRC_MODE     = 2'd0;
    localparam logic [1:0] REG_INIT_RETRIES = 2'd1;
    localparam logic [1:0] REG_PKT_RETRIES  = 2'd2;

    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HEADER, PH_SEQ, PH_CMP, PH_DATA,
        PH_TRL1, PH_TRL2, PH_FLUSH, PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        V_NONE, V_ACCEPTED, V_DUPLICATE, V_REJECTED, V_EOT, V_ABORTED
    } t_verdict;

    typedef struct packed {
        logic       crc_mode;
        logic [4:0] initial_retries;
        logic [4:0] packet_retries;
    } t_cfg;

    // one queued reply; abort expands to three CAN beats on the way out
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        t_verdict   verdict;
        logic       abort;
    } t_bundle;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* design/xbr_regs.sv */
// xbr_regs: apb-style configuration registers of the xmodem receiver.
// depends on xbr_pkg.
module xbr_regs import xbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_mode        <= 1'b1;
            r_cfg.initial_retries <= INIT_RETRIES_RST;
            r_cfg.packet_retries  <= PKT_RETRIES_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CRC_MODE:     r_cfg.crc_mode        <= pwdata[0];
                REG_INIT_RETRIES: r_cfg.initial_retries <= pwdata[4:0];
                REG_PKT_RETRIES:  r_cfg.packet_retries  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CRC_MODE:     prdata = {31'd0, r_cfg.crc_mode};
            REG_INIT_RETRIES: prdata = {27'd0, r_cfg.initial_retries};
            REG_PKT_RETRIES:  prdata = {27'd0, r_cfg.packet_retries};
            default:          prdata = 32'd0;
        endcase
    end
endmodule

/* design/xbr_core.sv */
// xbr_core: input register, protocol state and per-event step logic;
// pushes one reply bundle per event that answers. depends on xbr_pkg.
module xbr_core import xbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_rx_byte,
    input  logic       i_space,
    output logic       o_push,
    output t_bundle    o_bundle
);
    logic        r_in_valid;
    logic [1:0]  r_req;
    logic [7:0]  r_byte;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_expected, n_expected;
    logic [4:0]  r_retries, n_retries;
    logic [7:0]  r_reply, n_reply;
    logic        r_long, n_long;
    logic [10:0] r_count, n_count;
    logic [7:0]  r_blk, n_blk;
    logic [7:0]  r_cmp, n_cmp;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_trl_hi, n_trl_hi;

    logic        w_adv;
    logic        w_check_ok;
    logic        w_finish;
    logic [10:0] w_count_inc;

    assign w_adv   = r_in_valid & i_space;
    assign o_ready = ~r_in_valid | i_space;
    assign w_count_inc = r_count + 11'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req  <= i_req_type;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_expected <= 8'd1;
            r_retries  <= INIT_RETRIES_RST;
            r_reply    <= CCH;
            r_long     <= 1'b0;
            r_count    <= 11'd0;
            r_blk      <= 8'd0;
            r_cmp      <= 8'd0;
            r_crc      <= 16'd0;
            r_sum      <= 8'd0;
            r_trl_hi   <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_retries  <= n_retries;
            r_reply    <= n_reply;
            r_long     <= n_long;
            r_count    <= n_count;
            r_blk      <= n_blk;
            r_cmp      <= n_cmp;
            r_crc      <= n_crc;
            r_sum      <= n_sum;
            r_trl_hi   <= n_trl_hi;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_expected = r_expected;
        n_retries  = r_retries;
        n_reply    = r_reply;
        n_long     = r_long;
        n_count    = r_count;
        n_blk      = r_blk;
        n_cmp      = r_cmp;
        n_crc      = r_crc;
        n_sum      = r_sum;
        n_trl_hi   = r_trl_hi;
        o_push     = 1'b0;
        o_bundle   = '0;
        w_finish   = 1'b0;
        w_check_ok = 1'b0;

        if (w_adv) begin
            case (r_req)
                REQ_START: begin
                    n_expected = 8'd1;
                    n_retries  = i_cfg.initial_retries;
                    n_reply    = i_cfg.crc_mode ? CCH : NAK;
                    n_long     = 1'b0;
                    n_count    = 11'd0;
                    n_crc      = 16'd0;
                    n_sum      = 8'd0;
                    n_phase    = PH_HEADER;
                    o_push     = 1'b1;
                    o_bundle.tx_valid = 1'b1;
                    o_bundle.tx_byte  = n_reply;
                end
                REQ_BYTE: begin
                    case (r_phase)
                        PH_HEADER: begin
                            if (r_byte == SOH || r_byte == STX) begin
                                n_long  = (r_byte == STX);
                                n_count = 11'd0;
                                n_crc   = 16'd0;
                                n_sum   = 8'd0;
                                n_phase = PH_SEQ;
                            end else if (r_byte == EOT) begin
                                n_phase = PH_DONE;
                                o_push  = 1'b1;
                                o_bundle.tx_valid = 1'b1;
                                o_bundle.tx_byte  = ACK;
                                o_bundle.verdict  = V_EOT;
                            end
                        end
                        PH_SEQ: begin
                            n_blk   = r_byte;
                            n_phase = PH_CMP;
                        end
                        PH_CMP: begin
                            n_cmp   = r_byte;
                            n_phase = PH_DATA;
                        end
                        PH_DATA: begin
                            n_crc   = crc_byte(r_crc, r_byte);
                            n_sum   = r_sum + r_byte;
                            n_count = w_count_inc;
                            if (w_count_inc >= (r_long ? LONG_LEN : SHORT_LEN)) begin
                                n_phase = PH_TRL1;
                            end
                            o_push = 1'b1;
                            o_bundle.data_valid = 1'b1;
                            o_bundle.data_byte  = r_byte;
                        end
                        PH_TRL1: begin
                            if (i_cfg.crc_mode) begin
                                n_trl_hi = r_byte;
                                n_phase  = PH_TRL2;
                            end else begin
                                w_finish   = 1'b1;
                                w_check_ok = (r_byte == r_sum);
                            end
                        end
                        PH_TRL2: begin
                            w_finish   = 1'b1;
                            w_check_ok = ({r_trl_hi, r_byte} == r_crc);
                        end
                        default: ;
                    endcase
                end
                REQ_TIMEOUT: begin
                    if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                        o_push = 1'b1;
                        o_bundle.tx_valid = 1'b1;
                        if (r_retries <= 5'd1) begin
                            n_retries = 5'd0;
                            n_phase   = PH_DONE;
                            o_bundle.tx_byte = CAN;
                            o_bundle.abort   = 1'b1;
                        end else begin
                            n_retries = r_retries - 5'd1;
                            n_phase   = PH_HEADER;
                            o_bundle.tx_byte = r_reply;
                        end
                    end
                end
                default: ;
            endcase

            // verdict once the trailer is in
            if (w_finish) begin
                o_push = 1'b1;
                if (r_blk != ~r_cmp || !w_check_ok || r_blk != r_expected) begin
                    if (r_blk == ~r_cmp && w_check_ok && r_blk == r_expected - 8'd1) begin
                        n_reply = ACK;
                        n_phase = PH_HEADER;
                        o_bundle.tx_valid = 1'b1;
                        o_bundle.tx_byte  = ACK;
                        o_bundle.verdict  = V_DUPLICATE;
                    end else begin
                        n_reply = NAK;
                        n_phase = PH_FLUSH;
                        o_bundle.verdict = V_REJECTED;
                    end
                end else begin
                    n_expected = r_expected + 8'd1;
                    n_retries  = i_cfg.packet_retries;
                    n_reply    = ACK;
                    n_phase    = PH_HEADER;
                    o_bundle.tx_valid = 1'b1;
                    o_bundle.tx_byte  = ACK;
                    o_bundle.verdict  = V_ACCEPTED;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_space)
        else $error("reply pushed into a full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LONG_LEN)
        else $error("payload count ran past block length");
`endif
endmodule

/* design/xbr_outq.sv */
// xbr_outq: two-entry reply queue and output serializer; an abort entry
// goes out as three CAN beats. depends on xbr_pkg.
module xbr_outq import xbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_bundle    i_bundle,
    output logic       o_space,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_data_valid,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_verdict,
    output logic       o_last
);
    t_bundle    r_mem [2];
    logic       r_head;
    logic       r_tail;
    logic [1:0] r_cnt;
    logic [1:0] r_sub;
    t_bundle    w_hd;
    logic       w_beat;
    logic       w_pop;

    assign w_hd    = r_mem[r_head];
    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_beat  = o_valid & i_ready;
    assign o_last  = ~w_hd.abort | (r_sub == 2'd2);
    assign w_pop   = w_beat & o_last;

    assign o_tx_valid   = w_hd.tx_valid;
    assign o_tx_byte    = w_hd.tx_byte;
    assign o_data_valid = w_hd.data_valid;
    assign o_data_byte  = w_hd.data_byte;
    assign o_verdict    = (w_hd.abort && r_sub == 2'd2) ? V_ABORTED : w_hd.verdict;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
            r_sub  <= 2'd0;
        end else begin
            if (i_push) begin
                r_tail <= ~r_tail;
            end
            if (w_pop) begin
                r_head <= ~r_head;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
            // beat counter within an abort burst
            if (w_pop) begin
                r_sub <= 2'd0;
            end else if (w_beat) begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("reply queue overflow");
    a_sub_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> (o_valid && w_hd.abort))
        else $error("burst counter moved outside an abort");
`endif
endmodule

/* design/xmodem_block_receiver_unit.sv */
// channel   valid      ready      payload
// in        i_valid    o_ready    i_req_type, i_rx_byte
// out       o_valid    i_ready    o_tx_valid, o_tx_byte, o_data_valid, o_data_byte,
//                                 o_verdict, o_last
// cfg       psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// one event per cycle while the reply queue has space: an event is held in the input
// register, its state update and reply are computed there (crc-16 byte update
// included) and the reply lands in a two-entry queue whose head drives the outputs
// an abort reply takes three output beats; every other reply takes one
// synchronous active-low reset; no clearing pass, the block is ready right after
// input stalls only on a full queue: output stalls or a three-beat abort burst
//
// top level of the xmodem block receiver; depends on xbr_pkg, xbr_regs,
// xbr_core and xbr_outq
module xmodem_block_receiver_unit import xbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_verdict,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg    w_cfg;
    logic    w_space;
    logic    w_push;
    t_bundle w_bundle;

    xbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    xbr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_space    (w_space),
        .o_push     (w_push),
        .o_bundle   (w_bundle)
    );

    xbr_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_bundle     (w_bundle),
        .o_space      (w_space),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_verdict    (o_verdict),
        .o_last       (o_last)
    );
endmodule

/* test/xmodem_block_receiver_unit_tb.sv */
// xmodem_block_receiver_unit_tb: self-checking bench for the xmodem block receiver.
// it drives events through valid/ready, writes the registers over apb and checks every
// reply beat against an in-bench prediction. depends on xbr_pkg and the rtl only
module xmodem_block_receiver_unit_tb;
    import xbr_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_EVENTS  = 12;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        t_verdict   verdict;
        logic       last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_data_valid;
    logic [7:0]  o_data_byte;
    logic [2:0]  o_verdict;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    xmodem_block_receiver_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_data_valid (o_data_valid),
        .o_data_byte  (o_data_byte),
        .o_verdict    (o_verdict),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // register shadow, reset values
    logic       cfg_crc_mode     = 1'b1;
    logic [4:0] cfg_init_retries = INIT_RETRIES_RST;
    logic [4:0] cfg_pkt_retries  = PKT_RETRIES_RST;

    // session state of the prediction
    t_phase      sess_phase      = PH_IDLE;
    logic [7:0]  sess_next_blk   = 8'd1;
    logic [4:0]  sess_retries    = INIT_RETRIES_RST;
    logic [7:0]  sess_reply      = CCH;
    logic        sess_long       = 1'b0;
    logic [10:0] sess_count      = 11'd0;
    logic [7:0]  sess_blk_num    = 8'd0;
    logic [7:0]  sess_blk_cmp    = 8'd0;
    logic [15:0] sess_crc        = 16'd0;
    logic [7:0]  sess_sum        = 8'd0;
    logic [7:0]  sess_trl_hi     = 8'd0;

    t_reply expected_replies[$];
    t_reply pending_replies[$];
    t_reply want;
    t_reply got;

    int  mismatches   = 0;
    int  stall_cycles = 0;
    int  events_sent  = 0;
    bit  no_idle      = 1'b0;

    // check values of the block being sent
    logic [15:0] blk_crc;
    logic [7:0]  blk_sum;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(99) >= 18);
    end

    task automatic show_reply(input string tag, input t_reply r);
        $display("%s tx %0b/%02h data %0b/%02h verdict %0d last %0b", tag,
                 r.tx_valid, r.tx_byte, r.data_valid, r.data_byte, r.verdict, r.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_tx_valid, o_tx_byte, o_data_valid, o_data_byte,
                    t_verdict'(o_verdict), o_last};
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    show_reply("unexpected beat:", got);
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        show_reply("mismatch, expected:", want);
                        show_reply("mismatch, actual:  ", got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL xmodem_block_receiver_unit");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic add_reply(input logic txv, input logic [7:0] txb, input logic dv,
                             input logic [7:0] db, input t_verdict v);
        t_reply r;
        r = '{txv, txb, dv, db, v, 1'b0};
        pending_replies.push_back(r);
    endtask

    task automatic close_block(input logic check_ok);
        if (sess_blk_num != ~sess_blk_cmp || !check_ok) begin
            sess_reply = NAK;
            sess_phase = PH_FLUSH;
            add_reply(1'b0, 8'h00, 1'b0, 8'h00, V_REJECTED);
        end else if (sess_blk_num == sess_next_blk - 8'd1) begin
            sess_reply = ACK;
            sess_phase = PH_HEADER;
            add_reply(1'b1, ACK, 1'b0, 8'h00, V_DUPLICATE);
        end else if (sess_blk_num != sess_next_blk) begin
            sess_reply = NAK;
            sess_phase = PH_FLUSH;
            add_reply(1'b0, 8'h00, 1'b0, 8'h00, V_REJECTED);
        end else begin
            sess_next_blk = sess_next_blk + 8'd1;
            sess_retries  = cfg_pkt_retries;
            sess_reply    = ACK;
            sess_phase    = PH_HEADER;
            add_reply(1'b1, ACK, 1'b0, 8'h00, V_ACCEPTED);
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b);
        case (sess_phase)
            PH_HEADER: begin
                if (b == SOH || b == STX) begin
                    sess_long  = (b == STX);
                    sess_count = 11'd0;
                    sess_crc   = 16'd0;
                    sess_sum   = 8'd0;
                    sess_phase = PH_SEQ;
                end else if (b == EOT) begin
                    sess_phase = PH_DONE;
                    add_reply(1'b1, ACK, 1'b0, 8'h00, V_EOT);
                end
            end
            PH_SEQ: begin
                sess_blk_num = b;
                sess_phase   = PH_CMP;
            end
            PH_CMP: begin
                sess_blk_cmp = b;
                sess_phase   = PH_DATA;
            end
            PH_DATA: begin
                sess_crc   = crc16_step(sess_crc, b);
                sess_sum   = sess_sum + b;
                sess_count = sess_count + 11'd1;
                if (sess_count >= (sess_long ? LONG_LEN : SHORT_LEN))
                    sess_phase = PH_TRL1;
                add_reply(1'b0, 8'h00, 1'b1, b, V_NONE);
            end
            PH_TRL1: begin
                if (cfg_crc_mode) begin
                    sess_trl_hi = b;
                    sess_phase  = PH_TRL2;
                end else begin
                    close_block(b == sess_sum);
                end
            end
            PH_TRL2: close_block({sess_trl_hi, b} == sess_crc);
            default: ;
        endcase
    endtask

    task automatic take_timeout();
        if (sess_phase != PH_IDLE && sess_phase != PH_DONE) begin
            if (sess_retries <= 5'd1) begin
                sess_retries = 5'd0;
                sess_phase   = PH_DONE;
                add_reply(1'b1, CAN, 1'b0, 8'h00, V_NONE);
                add_reply(1'b1, CAN, 1'b0, 8'h00, V_NONE);
                add_reply(1'b1, CAN, 1'b0, 8'h00, V_ABORTED);
            end else begin
                sess_retries = sess_retries - 5'd1;
                sess_phase   = PH_HEADER;
                add_reply(1'b1, sess_reply, 1'b0, 8'h00, V_NONE);
            end
        end
    endtask

    task automatic predict_event(input logic [1:0] req, input logic [7:0] b);
        t_reply r;
        pending_replies.delete();
        case (req)
            REQ_START: begin
                sess_next_blk = 8'd1;
                sess_retries  = cfg_init_retries;
                sess_reply    = cfg_crc_mode ? CCH : NAK;
                sess_long     = 1'b0;
                sess_count    = 11'd0;
                sess_crc      = 16'd0;
                sess_sum      = 8'd0;
                sess_phase    = PH_HEADER;
                add_reply(1'b1, sess_reply, 1'b0, 8'h00, V_NONE);
            end
            REQ_BYTE:    take_rx_byte(b);
            REQ_TIMEOUT: take_timeout();
            default: ;
        endcase
        for (int i = 0; i < pending_replies.size(); i++) begin
            r = pending_replies[i];
            r.last = (i == pending_replies.size() - 1);
            expected_replies.push_back(r);
        end
    endtask

    // entered and left just after a falling edge
    task automatic send_event(input logic [1:0] req, input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_req_type = req;
        i_rx_byte  = b;
        do
            @(posedge i_clk);
        while (!o_ready);
        predict_event(req, b);
        events_sent++;
        @(negedge i_clk);
    endtask

    // hold the input until every reply is out and the input stage is empty
    task automatic drain_replies();
        i_valid = 1'b0;
        while (expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
        drain_replies();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = {27'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_CRC_MODE:     cfg_crc_mode     = val[0];
            REG_INIT_RETRIES: cfg_init_retries = val;
            REG_PKT_RETRIES:  cfg_pkt_retries  = val;
            default: ;
        endcase
    endtask

    // trailer in the mode the register holds right now
    task automatic send_trailer(input bit bad_check);
        logic [7:0] flip;
        logic [7:0] hi_flip;
        logic [7:0] lo_flip;
        flip    = bad_check ? (8'h01 << $urandom_range(7)) : 8'h00;
        hi_flip = 8'h00;
        lo_flip = 8'h00;
        if ($urandom_range(1))
            hi_flip = flip;
        else
            lo_flip = flip;
        if (cfg_crc_mode) begin
            send_event(REQ_BYTE, blk_crc[15:8] ^ hi_flip);
            send_event(REQ_BYTE, blk_crc[7:0] ^ lo_flip);
        end else begin
            send_event(REQ_BYTE, blk_sum ^ flip);
        end
    endtask

    task automatic send_block(input bit long_blk, input logic [7:0] num, input logic [7:0] cmp,
                              input int n_data, input bit with_trailer, input bit bad_check);
        int         len;
        logic [7:0] d;
        len = long_blk ? 1024 : 128;
        send_event(REQ_BYTE, long_blk ? STX : SOH);
        send_event(REQ_BYTE, num);
        send_event(REQ_BYTE, cmp);
        blk_crc = 16'd0;
        blk_sum = 8'd0;
        for (int i = 0; i < n_data && i < len; i++) begin
            d = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom_range(255));
            blk_crc = crc16_step(blk_crc, d);
            blk_sum = blk_sum + d;
            send_event(REQ_BYTE, d);
        end
        if (with_trailer)
            send_trailer(bad_check);
    endtask

    task automatic send_good_block();
        send_block(1'b0, sess_next_blk, ~sess_next_blk, 128, 1'b1, 1'b0);
    endtask

    task automatic test_quiet_before_start();
        send_event(REQ_BYTE, SOH);
        send_event(REQ_TIMEOUT, 8'hff);
        send_event(REQ_UNUSED, 8'hff);
    endtask

    task automatic test_open_and_eot();
        send_event(REQ_START, 8'h00);
        send_event(REQ_BYTE, 8'h00);
        send_event(REQ_BYTE, 8'hff);
        send_event(REQ_BYTE, CCH);
        send_event(REQ_UNUSED, 8'h55);
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_BYTE, EOT);
        // session over: nothing answers until the next start
        send_event(REQ_BYTE, SOH);
        send_event(REQ_TIMEOUT, 8'h00);
    endtask

    // crc block with no idling on either side; budget reload checked later
    task automatic test_accepted_block();
        cfg_write(REG_PKT_RETRIES, 5'd3);
        no_idle = 1'b1;
        send_event(REQ_START, 8'h00);
        send_good_block();
        no_idle = 1'b0;
    endtask

    // block 1 again, trailer format follows the register at the first trailer byte
    task automatic test_duplicate_mode_switch();
        send_block(1'b0, 8'd1, ~8'd1, 128, 1'b0, 1'b0);
        cfg_write(REG_CRC_MODE, 5'd0);
        send_trailer(1'b0);
        cfg_write(REG_CRC_MODE, 5'd1);
    endtask

    task automatic test_rejected_block();
        send_block(1'b0, sess_next_blk, ~sess_next_blk ^ 8'h10, 128, 1'b1, 1'b0);
        send_event(REQ_BYTE, SOH);
        send_event(REQ_BYTE, 8'hff);
        send_event(REQ_TIMEOUT, 8'h00);
    endtask

    task automatic test_long_block_abort();
        send_block(1'b1, sess_next_blk, ~sess_next_blk, 5, 1'b0, 1'b0);
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_BYTE, SOH);
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_BYTE, EOT);
    endtask

    task automatic test_retry_budget();
        cfg_write(REG_INIT_RETRIES, 5'd1);
        send_event(REQ_START, 8'h00);
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_TIMEOUT, 8'h00);
        // an empty budget behaves like a budget of one
        cfg_write(REG_INIT_RETRIES, 5'd0);
        send_event(REQ_START, 8'h00);
        send_event(REQ_TIMEOUT, 8'h00);
        cfg_write(REG_INIT_RETRIES, 5'd2);
        send_event(REQ_START, 8'h00);
        send_event(REQ_TIMEOUT, 8'h00);
        send_event(REQ_TIMEOUT, 8'h00);
    endtask

    task automatic random_scenario();
        int pick;
        pick = $urandom_range(99);
        if (sess_phase == PH_IDLE || sess_phase == PH_DONE) begin
            send_event(REQ_START, 8'($urandom_range(255)));
        end else if (pick < 40) begin
            send_block(1'($urandom_range(1)), sess_next_blk, ~sess_next_blk,
                       $urandom_range(6), 1'b0, 1'b0);
            send_event(REQ_TIMEOUT, 8'($urandom_range(255)));
        end else if (pick < 50) begin
            send_event(REQ_START, 8'($urandom_range(255)));
        end else if (pick < 58) begin
            send_event(REQ_BYTE, EOT);
        end else if (pick < 85) begin
            send_event(2'($urandom_range(3)), 8'($urandom_range(255)));
        end else begin
            send_event(REQ_TIMEOUT, 8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_traffic(input logic crc, input logic [4:0] init_r,
                                       input logic [4:0] pkt_r);
        int start_count;
        cfg_write(REG_CRC_MODE, {4'd0, crc});
        cfg_write(REG_INIT_RETRIES, init_r);
        cfg_write(REG_PKT_RETRIES, pkt_r);
        start_count = events_sent;
        while (events_sent - start_count < RANDOM_EVENTS) begin
            random_scenario();
            if ($urandom_range(99) < 3)
                drain_replies();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_req_type = REQ_START;
        i_rx_byte  = 8'h00;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 4'd0;
        pwdata     = 32'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_quiet_before_start();
        test_open_and_eot();
        test_accepted_block();
        test_duplicate_mode_switch();
        test_rejected_block();
        test_long_block_abort();
        test_retry_budget();
        test_random_traffic(1'($urandom_range(1)), 5'($urandom_range(31)),
                            5'($urandom_range(31)));

        drain_replies();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("PASS xmodem_block_receiver_unit");
        end else begin
            $display("FAIL xmodem_block_receiver_unit");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/xbr_pkg.sv
design/xbr_regs.sv
design/xbr_core.sv
design/xbr_outq.sv
design/xmodem_block_receiver_unit.sv
test/xmodem_block_receiver_unit_tb.sv
